// ----- src/btop_pkg.sv -----
// Shared types and constants for the binomial tree option pricer.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package btop_pkg;

    localparam int DEFAULT_MAX_STEPS = 256;
    localparam int PRICE_W           = 32;
    localparam int FACTOR_SHIFT      = 30;
    localparam int CFG_IDX_W         = 3;

    localparam logic [30:0] FACTOR_ONE  = 31'h4000_0000;
    localparam logic [30:0] FACTOR_HALF = 31'h2000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP_FACTOR   = 3'd0,
        CFG_DOWN_FACTOR = 3'd1,
        CFG_PROB_UP     = 3'd2,
        CFG_DISCOUNT    = 3'd3,
        CFG_NUM_STEPS   = 3'd4,
        CFG_AMERICAN    = 3'd5
    } t_cfg_idx;

    // One tree node as it travels down the cell chain.
    typedef struct packed {
        logic [PRICE_W-1:0] asset;
        logic [PRICE_W-1:0] value;
    } t_node;

    typedef struct packed {
        logic shift;
        logic write;
    } t_cell_ctl;

    typedef struct packed {
        logic load;
        logic pop;
        logic push;
    } t_chain_ctl;

    typedef struct packed {
        logic               valid;
        logic               backward;
        logic               use_up;
        logic [PRICE_W-1:0] asset;
        logic [PRICE_W-1:0] v_down;
        logic [PRICE_W-1:0] v_up;
    } t_issue;

    typedef struct packed {
        logic [31:0]        up;
        logic [30:0]        down;
        logic [30:0]        p;
        logic [30:0]        q;
        logic [30:0]        disc;
        logic [PRICE_W-1:0] strike;
        logic               american;
    } t_coef;

endpackage

`default_nettype wire

// ----- src/btop_cell.sv -----
// One storage cell of the node chain: holds a node, loads from its neighbor
// or from the insert bus. Depends on btop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btop_cell
    import btop_pkg::*;
(
    input  wire        i_clk,
    input  t_cell_ctl  i_ctl,
    input  t_node      i_next,
    input  t_node      i_din,
    output t_node      o_node
);

    t_node r_node;
    t_node n_node;

    // An insert wins over the shift, so a cell can take new data while the
    // rest of the chain moves.
    always_comb begin
        n_node = r_node;
        priority if (i_ctl.write) begin
            n_node = i_din;
        end else if (i_ctl.shift) begin
            n_node = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
    end

    assign o_node = r_node;

endmodule

`default_nettype wire

// ----- src/btop_chain.sv -----
// Node queue built as a row of cells: pops shift every cell toward the head,
// pushes insert behind the last occupied cell. Depends on btop_pkg, btop_cell.
`timescale 1ns / 1ps
`default_nettype none

module btop_chain
    import btop_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_STEPS + 1
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_chain_ctl i_ctl,
    input  t_node      i_load_node,
    input  t_node      i_push_node,
    output t_node      o_head,
    output logic       o_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_node            w_din;
    t_node            w_q [DEPTH];

    assign w_din = i_ctl.load ? i_load_node : i_push_node;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        localparam logic [CNT_W-1:0] K = CNT_W'(k);
        t_node     w_next;
        t_cell_ctl w_ctl;

        if (k == DEPTH - 1) begin : g_tail
            assign w_next = w_din;
        end else begin : g_body
            assign w_next = w_q[k+1];
        end

        // The insert slot is the first free cell after this cycle's shift.
        always_comb begin
            w_ctl.shift = i_ctl.pop && !i_ctl.load;
            priority if (i_ctl.load) begin
                w_ctl.write = (k == 0);
            end else if (i_ctl.pop) begin
                w_ctl.write = i_ctl.push && (r_count == K + CNT_W'(1));
            end else begin
                w_ctl.write = i_ctl.push && (r_count == K);
            end
        end

        btop_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_next (w_next),
            .i_din  (w_din),
            .o_node (w_q[k])
        );
    end

    always_comb begin
        n_count = r_count;
        priority if (i_ctl.load) begin
            n_count = CNT_W'(1);
        end else if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.pop && !i_ctl.push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_head  = w_q[0];
    assign o_empty = (r_count == '0);

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.pop && !i_ctl.load) |-> (r_count != '0))
        else $error("chain popped while empty");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CNT_W'(DEPTH)) |-> !(i_ctl.push && !i_ctl.pop && !i_ctl.load))
        else $error("chain pushed while full");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |=> (r_count == CNT_W'(1)))
        else $error("chain load did not leave a single entry");

endmodule

`default_nettype wire

// ----- src/btop_datapath.sv -----
// Shared three-stage arithmetic pipeline: price scaling and payoff for the
// forward build, weighted mix, discount and early exercise for the backward pass.
// Depends on btop_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btop_datapath
    import btop_pkg::*;
(
    input  wire    i_clk,
    input  wire    i_rst_n,
    input  t_issue i_issue,
    input  t_coef  i_coef,
    output logic   o_push_valid,
    output t_node  o_push_node,
    output logic   o_busy
);

    // Drop the Q2.30 fraction and clamp to the price range.
    function automatic logic [PRICE_W-1:0] sat_shift(input logic [63:0] v);
        logic [63:0] s;
        s = v >> FACTOR_SHIFT;
        return (|s[63:PRICE_W]) ? {PRICE_W{1'b1}} : s[PRICE_W-1:0];
    endfunction

    logic               r_v1, r_v2, r_v3;
    logic               r_bwd1, r_bwd2, r_bwd3;
    logic [63:0]        r_prod_s;
    logic [62:0]        r_prod_u;
    logic [62:0]        r_prod_d;
    logic [PRICE_W-1:0] r_mix;
    logic [PRICE_W-1:0] r_s2;
    logic [62:0]        r_prod_c;
    logic [PRICE_W-1:0] r_ex;
    logic [PRICE_W-1:0] r_s3;

    logic [31:0]        w_factor;
    logic [PRICE_W-1:0] w_cont;

    // The backward pass recovers asset prices with the down factor as well.
    assign w_factor = (i_issue.backward || !i_issue.use_up) ? {1'b0, i_coef.down}
                                                            : i_coef.up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_issue.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bwd1   <= i_issue.backward;
        r_prod_s <= 64'(i_issue.asset) * 64'(w_factor);
        r_prod_u <= 63'(i_coef.p) * 63'(i_issue.v_up);
        r_prod_d <= 63'(i_coef.q) * 63'(i_issue.v_down);

        r_bwd2   <= r_bwd1;
        r_mix    <= sat_shift(64'(r_prod_u) + 64'(r_prod_d));
        r_s2     <= sat_shift(r_prod_s);

        r_bwd3   <= r_bwd2;
        r_prod_c <= 63'(r_mix) * 63'(i_coef.disc);
        r_ex     <= (r_s2 > i_coef.strike) ? r_s2 - i_coef.strike : '0;
        r_s3     <= r_s2;
    end

    assign w_cont = sat_shift(64'(r_prod_c));

    always_comb begin
        o_push_node.asset = r_s3;
        if (!r_bwd3) begin
            o_push_node.value = r_ex;
        end else if (i_coef.american && (r_ex > w_cont)) begin
            o_push_node.value = r_ex;
        end else begin
            o_push_node.value = w_cont;
        end
    end

    assign o_push_valid = r_v3;
    assign o_busy       = r_v1 || r_v2 || r_v3;

endmodule

`default_nettype wire

// ----- src/binomial_tree_option_pricer_unit.sv -----
// Binomial tree call option pricer: sequencer, configuration registers and
// output register. Depends on btop_pkg, btop_chain and btop_datapath.
//
// Usage: a request (spot and strike, unsigned Q16.16) is a transfer on the
// input channel (i_in_valid / o_in_ready). One price comes back per request
// on the output channel (o_out_valid / i_out_ready). The configuration port
// takes a write on every cycle with i_cfg_we high; write it only while idle.
// For n tree steps the node queue is rebuilt once per level, forward and then
// backward, with one node entering the arithmetic pipeline per cycle while
// the queue holds entries. The shortest levels stall, waiting for results
// still in the three-stage pipeline.
// One request is worked on at a time. The finished price sits in the output
// register; the next request is accepted as soon as the price has moved there,
// even if the receiver has not taken it yet. If the receiver stalls with a
// price still held, the block waits with its finished result until it can be
// moved. Reset clears all control state and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module binomial_tree_option_pricer_unit
    import btop_pkg::*;
#(
    parameter int MAX_STEPS = DEFAULT_MAX_STEPS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [31:0]          i_cfg_wdata,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire [PRICE_W-1:0]   i_spot_price,
    input  wire [PRICE_W-1:0]   i_strike_price,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic [PRICE_W-1:0]  o_option_price
);

    localparam int LVL_W = $clog2(MAX_STEPS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FWD,
        ST_BWD,
        ST_DRAIN
    } t_state;

    // Configuration registers.
    logic [31:0]        r_up_factor;
    logic [30:0]        r_down_factor;
    logic [30:0]        r_prob_up;
    logic [30:0]        r_discount_factor;
    logic [8:0]         r_num_steps;
    logic               r_american_mode;

    t_state             r_state;
    logic [LVL_W-1:0]   r_lvl;
    logic [LVL_W-1:0]   r_node;
    logic [LVL_W-1:0]   r_n;
    logic               r_out_valid;
    logic [PRICE_W-1:0] r_out_price;

    logic [30:0]        r_p;
    logic [30:0]        r_q;
    logic [PRICE_W-1:0] r_strike;
    logic               r_mode_am;
    logic [PRICE_W-1:0] r_prev;

    logic               w_accept;
    logic [LVL_W-1:0]   w_n;
    logic [30:0]        w_p;
    logic [LVL_W-1:0]   w_lvl_next;
    logic [LVL_W-1:0]   w_last_lvl;
    logic               w_pop;
    logic               w_empty;
    logic               w_busy;
    logic               w_push_valid;
    t_node              w_push_node;
    t_node              w_head;
    t_node              w_load_node;
    t_issue             w_issue;
    t_coef              w_coef;
    t_chain_ctl         w_chain_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_factor       <= {1'b0, FACTOR_ONE};
            r_down_factor     <= FACTOR_ONE;
            r_prob_up         <= FACTOR_HALF;
            r_discount_factor <= FACTOR_ONE;
            r_num_steps       <= 9'd1;
            r_american_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_UP_FACTOR:   r_up_factor       <= i_cfg_wdata;
                CFG_DOWN_FACTOR: r_down_factor     <= i_cfg_wdata[30:0];
                CFG_PROB_UP:     r_prob_up         <= i_cfg_wdata[30:0];
                CFG_DISCOUNT:    r_discount_factor <= i_cfg_wdata[30:0];
                CFG_NUM_STEPS:   r_num_steps       <= i_cfg_wdata[8:0];
                CFG_AMERICAN:    r_american_mode   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_accept = i_in_valid && o_in_ready;

    // A zero step count runs one step; counts above MAX_STEPS are capped to it.
    always_comb begin
        if (r_num_steps == '0) begin
            w_n = LVL_W'(1);
        end else if (32'(r_num_steps) > 32'(MAX_STEPS)) begin
            w_n = LVL_W'(MAX_STEPS);
        end else begin
            w_n = LVL_W'(r_num_steps);
        end
    end

    assign w_p        = (r_prob_up > FACTOR_ONE) ? FACTOR_ONE : r_prob_up;
    assign w_lvl_next = r_lvl + LVL_W'(1);
    assign w_last_lvl = r_n - LVL_W'(1);

    // Forward level i issues i+2 operations: the head with the down factor,
    // then every entry with the up factor as it is popped. Backward level l
    // pops l+2 entries; each pop after the first pairs the head with the
    // entry popped before it.
    always_comb begin
        w_issue        = '0;
        w_issue.asset  = w_head.asset;
        w_issue.v_up   = w_head.value;
        w_issue.v_down = r_prev;
        w_pop          = 1'b0;
        unique case (r_state)
            ST_FWD: begin
                w_issue.valid  = !w_empty;
                w_issue.use_up = (r_node != '0);
                w_pop          = !w_empty && (r_node != '0);
            end
            ST_BWD: begin
                w_pop            = !w_empty;
                w_issue.valid    = !w_empty && (r_node != '0);
                w_issue.backward = 1'b1;
            end
            default: ;
        endcase
    end

    assign w_load_node = '{asset: i_spot_price, value: '0};
    assign w_chain_ctl = '{load: w_accept, pop: w_pop, push: w_push_valid};

    assign w_coef = '{
        up:       r_up_factor,
        down:     r_down_factor,
        p:        r_p,
        q:        r_q,
        disc:     r_discount_factor,
        strike:   r_strike,
        american: r_mode_am
    };

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lvl       <= '0;
            r_node      <= '0;
            r_out_valid <= 1'b0;
            r_out_price <= '0;
        end else begin
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_FWD;
                        r_lvl   <= '0;
                        r_node  <= '0;
                    end
                end
                ST_FWD: begin
                    if (w_issue.valid) begin
                        if (r_node == w_lvl_next) begin
                            r_node <= '0;
                            // The backward pass starts on the level below the leaves.
                            if (r_lvl == w_last_lvl) begin
                                r_state <= ST_BWD;
                            end else begin
                                r_lvl <= w_lvl_next;
                            end
                        end else begin
                            r_node <= r_node + LVL_W'(1);
                        end
                    end
                end
                ST_BWD: begin
                    if (w_pop) begin
                        if (r_node == w_lvl_next) begin
                            r_node <= '0;
                            if (r_lvl == '0) begin
                                r_state <= ST_DRAIN;
                            end else begin
                                r_lvl <= r_lvl - LVL_W'(1);
                            end
                        end else begin
                            r_node <= r_node + LVL_W'(1);
                        end
                    end
                end
                ST_DRAIN: begin
                    // Once the pipeline is empty the root value is the only entry.
                    if (!w_busy && (!r_out_valid || i_out_ready)) begin
                        r_out_valid <= 1'b1;
                        r_out_price <= w_head.value;
                        r_state     <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_n       <= w_n;
            r_p       <= w_p;
            r_q       <= FACTOR_ONE - w_p;
            r_strike  <= i_strike_price;
            r_mode_am <= r_american_mode;
        end
        if ((r_state == ST_BWD) && w_pop) begin
            r_prev <= w_head.value;
        end
    end

    btop_chain #(
        .DEPTH (MAX_STEPS + 1)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_chain_ctl),
        .i_load_node (w_load_node),
        .i_push_node (w_push_node),
        .o_head      (w_head),
        .o_empty     (w_empty)
    );

    btop_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_issue      (w_issue),
        .i_coef       (w_coef),
        .o_push_valid (w_push_valid),
        .o_push_node  (w_push_node),
        .o_busy       (w_busy)
    );

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_option_price = r_out_price;

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_busy)
        else $error("arithmetic pipeline busy while idle");

    a_issue_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue.valid |-> ((r_state == ST_FWD) || (r_state == ST_BWD)))
        else $error("node issued outside a tree pass");

    a_root_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DRAIN) && !w_busy) |-> !w_empty)
        else $error("no root value in the chain at the end of a request");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_FWD))
        else $error("accepted request did not start the forward build");

endmodule

`default_nettype wire
